@@ rtl/pfe_pkg.sv @@
// Shared constants and types for the postfix expression evaluator.
package pfe_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int VALUE_OUT_W     = 32;
  localparam int STATUS_W        = 3;
  localparam int TALLY_W         = 16;

  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOOP    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_COUNT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVER    = 3'd5;

  // Command broadcast to every stack cell
  typedef enum logic [1:0] {
    SOP_HOLD = 2'd0,
    SOP_PUSH = 2'd1,
    SOP_POP  = 2'd2
  } stack_op_t;

  // Request to the iterative multiply/divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } alu_req_t;

endpackage

@@ rtl/pfe_cell.sv @@
// One stack cell: takes its upper neighbor on push, its lower neighbor on pop.
module pfe_cell import pfe_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  stack_op_t              sop,
  input  logic [VALUE_WIDTH-1:0] push_in,
  input  logic [VALUE_WIDTH-1:0] pop_in,
  output logic [VALUE_WIDTH-1:0] data
);

  always_ff @(posedge clk) begin
    case (sop)
      SOP_PUSH: data <= push_in;
      SOP_POP:  data <= pop_in;
      default:  data <= data;
    endcase
  end

endmodule

@@ rtl/pfe_alu.sv @@
// Iterative multiply (shift-add) and signed divide (restoring), one bit a cycle.
module pfe_alu import pfe_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  alu_req_t               req,
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  output logic                   busy,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] result
);

  localparam int W     = VALUE_WIDTH;
  localparam int CNT_W = $clog2(W);

  logic [CNT_W-1:0] cnt;
  logic             is_div;
  logic             neg;
  logic [W-1:0]     p;    // multiplicand / dividend
  logic [W-1:0]     q;    // multiplier / quotient
  logic [W-1:0]     r;    // product / remainder
  logic [W-1:0]     d;    // divisor magnitude
  logic [W:0]       rem_sh;
  logic [W:0]       rem_sub;
  logic [W-1:0]     a_mag;
  logic [W-1:0]     b_mag;

  assign a_mag   = a[W-1] ? (~a + 1'b1) : a;
  assign b_mag   = b[W-1] ? (~b + 1'b1) : b;
  assign rem_sh  = {r, p[W-1]};
  assign rem_sub = rem_sh - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (busy) begin
        busy <= (cnt != '0);
        cnt  <= cnt - 1'b1;
      end else if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && req.start) begin
      is_div <= req.is_div;
      neg    <= a[W-1] ^ b[W-1];
      r      <= '0;
      if (req.is_div) begin
        p <= a_mag;
        q <= '0;
        d <= b_mag;
      end else begin
        p <= a;
        q <= b;
        d <= b;
      end
    end else if (busy) begin
      p <= p << 1;
      if (is_div) begin
        if (!rem_sub[W]) begin
          r <= rem_sub[W-1:0];
          q <= {q[W-2:0], 1'b1};
        end else begin
          r <= rem_sh[W-1:0];
          q <= {q[W-2:0], 1'b0};
        end
      end else begin
        q <= q >> 1;
        if (q[0]) r <= r + p;
      end
    end
  end

  assign result = is_div ? (neg ? (~q + 1'b1) : q) : r;

endmodule

@@ rtl/postfix_expression_evaluator.sv @@
// Postfix evaluator top level: control, counters, cell-chain stack and result register.
// Digits, '+', '-', unknown characters and zero divides are handled in the idle state; '*' and '/'
//   go through the busy state while the one-bit-per-cycle multiply/divide unit runs.
// A last item then passes the finish state to load the result register, waiting there while
//   the previous result is still unread. The block works one item at a time.
// Reset (rst, synchronous): clears stack count, counters, error and result valid;
//   stack cell contents are left as they are and only ever read below the count.
module postfix_expression_evaluator import pfe_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   char_valid,
  output logic                   char_ready,
  input  logic [7:0]             char_code,
  input  logic                   last_char,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic [VALUE_OUT_W-1:0] value,
  output logic [STATUS_W-1:0]    status
);

  localparam int W     = VALUE_WIDTH;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  // One-hot control states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_BUSY = 3'b010,   // multiply/divide in flight
    S_FIN  = 3'b100    // load the result register
  } state_t;

  state_t              state, state_next;
  logic [CNT_W-1:0]    sp, sp_next;         // values on the stack
  logic [TALLY_W-1:0]  dig_cnt, dig_cnt_next;
  logic [TALLY_W-1:0]  op_cnt, op_cnt_next;
  logic [STATUS_W-1:0] err, err_next;       // first run-time error, sticky
  logic                last_q;              // last flag of the item in flight

  logic [W-1:0]        cell_q [STACK_DEPTH];
  stack_op_t           sop;
  logic [W-1:0]        push_val;
  logic [W-1:0]        pop_val;             // result written to the top cell

  alu_req_t            alu_req;
  logic                alu_busy;
  logic                alu_done;
  logic [W-1:0]        alu_result;

  logic                accept;
  logic                is_digit;
  logic [7:0]          digit;
  logic                fin_take;
  logic [VALUE_OUT_W-1:0] top_out;
  logic [STATUS_W-1:0] fin_status;

  assign char_ready = (state == S_IDLE);
  assign accept     = char_valid && char_ready;
  assign is_digit   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign digit      = char_code - CH_ZERO;
  assign push_val   = {{(W-4){1'b0}}, digit[3:0]};
  assign fin_take   = (state == S_FIN) && (!result_valid || result_ready);

  // Item decode and stack command
  always_comb begin
    state_next     = state;
    sp_next        = sp;
    dig_cnt_next   = dig_cnt;
    op_cnt_next    = op_cnt;
    err_next       = err;
    sop            = SOP_HOLD;
    pop_val        = '0;
    alu_req.start  = 1'b0;
    alu_req.is_div = (char_code == CH_DIV);

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = last_char ? S_FIN : S_IDLE;
          if (is_digit) begin
            if (dig_cnt != TALLY_MAX) dig_cnt_next = dig_cnt + 1'b1;
            if (sp == CNT_W'(STACK_DEPTH)) begin
              if (err == ST_OK) err_next = ST_OVER;
            end else begin
              sop     = SOP_PUSH;
              sp_next = sp + 1'b1;
            end
          end else begin
            if (op_cnt != TALLY_MAX) op_cnt_next = op_cnt + 1'b1;
            if (sp < CNT_W'(2)) begin
              if (err == ST_OK) err_next = ST_UNDER;
            end else begin
              // a is one below the top, b is the top
              case (char_code)
                CH_PLUS: begin
                  sop     = SOP_POP;
                  pop_val = cell_q[1] + cell_q[0];
                  sp_next = sp - 1'b1;
                end
                CH_MINUS: begin
                  sop     = SOP_POP;
                  pop_val = cell_q[1] - cell_q[0];
                  sp_next = sp - 1'b1;
                end
                CH_MUL, CH_DIV: begin
                  if (char_code == CH_DIV && cell_q[0] == '0) begin
                    // divide by zero: pop both, push 0
                    sop     = SOP_POP;
                    sp_next = sp - 1'b1;
                    if (err == ST_OK) err_next = ST_DIVZERO;
                  end else begin
                    alu_req.start = 1'b1;
                    state_next    = S_BUSY;
                  end
                end
                default: begin
                  // unknown operator pops two and pushes 0
                  sop     = SOP_POP;
                  sp_next = sp - 1'b1;
                end
              endcase
            end
          end
        end
      end
      S_BUSY: begin
        if (alu_done) begin
          sop        = SOP_POP;
          pop_val    = alu_result;
          sp_next    = sp - 1'b1;
          state_next = last_q ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (fin_take) begin
          sp_next      = '0;
          dig_cnt_next = '0;
          op_cnt_next  = '0;
          err_next     = ST_OK;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      sp      <= '0;
      dig_cnt <= '0;
      op_cnt  <= '0;
      err     <= ST_OK;
      last_q  <= 1'b0;
    end else begin
      state   <= state_next;
      sp      <= sp_next;
      dig_cnt <= dig_cnt_next;
      op_cnt  <= op_cnt_next;
      err     <= err_next;
      if (accept) last_q <= last_char;
    end
  end

  // Stack as a chain of cells; cell 0 is the top
  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      logic [W-1:0] up_in;
      logic [W-1:0] dn_in;
      if (gi == 0) begin : g_top
        assign up_in = push_val;
        assign dn_in = pop_val;
      end else if (gi == STACK_DEPTH - 1) begin : g_bot
        assign up_in = cell_q[gi-1];
        assign dn_in = cell_q[gi];
      end else begin : g_mid
        assign up_in = cell_q[gi-1];
        assign dn_in = cell_q[gi+1];
      end
      pfe_cell #(.VALUE_WIDTH(W)) u_cell (
        .clk     (clk),
        .sop     (sop),
        .push_in (up_in),
        .pop_in  (dn_in),
        .data    (cell_q[gi])
      );
    end
  endgenerate

  pfe_alu #(.VALUE_WIDTH(W)) u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (cell_q[1]),
    .b      (cell_q[0]),
    .busy   (alu_busy),
    .done   (alu_done),
    .result (alu_result)
  );

  // Top of stack to output width: low bits, zero-extended when narrower
  generate
    if (W >= VALUE_OUT_W) begin : g_trunc
      assign top_out = cell_q[0][VALUE_OUT_W-1:0];
    end else begin : g_ext
      assign top_out = {{(VALUE_OUT_W-W){1'b0}}, cell_q[0]};
    end
  endgenerate

  // Recorded error first, then missing operator, then operand count
  always_comb begin
    if (err != ST_OK)
      fin_status = err;
    else if (op_cnt == '0)
      fin_status = ST_NOOP;
    else if ({1'b0, dig_cnt} != ({1'b0, op_cnt} + 17'd1))
      fin_status = ST_COUNT;
    else
      fin_status = ST_OK;
  end

  // Result register: lets the next item in while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fin_take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      value  <= (sp == '0) ? '0 : top_out;
      status <= fin_status;
    end
  end

  a_alu_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !alu_busy)
    else $error("multiply/divide unit busy while control is idle");

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_FIN)
    else $error("result raised outside the finish state");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    fin_take |=> (sp == '0) && (dig_cnt == '0) && (op_cnt == '0) && (err == ST_OK))
    else $error("expression state not cleared after result");

endmodule

@@ tb/sv/postfix_expression_evaluator_tb.sv @@
// Self-checking testbench for the postfix evaluator: character streams checked against a stack calculator.
module postfix_expression_evaluator_tb import pfe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int VW    = VALUE_WIDTH_DEF;

  // Slowest legal quiet stretch: '*' or '/', a long sender gap and a long receiver stall
  // back to back. The limit is many times that.
  localparam int STALL_LIMIT  = 3000;
  // Settle time after the last result: one full multiply/divide plus the result load.
  localparam int DRAIN_CYCLES = VW + 16;
  // Random items on top of about a hundred directed ones
  localparam int RANDOM_ITEMS = 540;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } char_item_t;

  typedef struct {
    logic [VALUE_OUT_W-1:0] value;
    logic [STATUS_W-1:0]    status;
  } expr_result_t;

  // Every input starts at a known value; reset is held from time zero.
  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   char_valid   = 1'b0;
  logic                   char_ready;
  logic [7:0]             char_code    = 8'h00;
  logic                   last_char    = 1'b0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  logic [VALUE_OUT_W-1:0] value;
  logic [STATUS_W-1:0]    status;

  postfix_expression_evaluator #(
    .STACK_DEPTH(DEPTH),
    .VALUE_WIDTH(VW)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_code   (char_code),
    .last_char   (last_char),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .value       (value),
    .status      (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Stack calculator: mirrors the block's state, one call per accepted item
  // ---------------------------------------------------------------------------
  logic [VW-1:0]       calc_stack [DEPTH];
  int                  calc_depth  = 0;
  logic [TALLY_W-1:0]  digits_seen = '0;
  logic [TALLY_W-1:0]  ops_seen    = '0;
  logic [STATUS_W-1:0] first_error = ST_OK;
  expr_result_t        expected_results [$];
  int                  mismatches  = 0;

  // One binary operation; divide truncates toward zero, everything wraps at VW bits.
  function automatic logic [VW-1:0] combine(input logic [7:0] op, input logic [VW-1:0] a,
                                            input logic [VW-1:0] b, output bit dz);
    logic [VW-1:0] ma, mb, q;
    dz = 1'b0;
    case (op)
      CH_PLUS:  return a + b;
      CH_MINUS: return a - b;
      CH_MUL:   return a * b;
      CH_DIV: begin
        if (b == '0) begin
          dz = 1'b1;
          return '0;
        end
        ma = a[VW-1] ? (~a + 1'b1) : a;
        mb = b[VW-1] ? (~b + 1'b1) : b;
        q  = ma / mb;
        // most negative / -1 falls out of this as the most negative value again
        return (a[VW-1] ^ b[VW-1]) ? (~q + 1'b1) : q;
      end
      default:  return '0;  // unknown character still consumes two operands
    endcase
  endfunction

  task automatic apply_char(input logic [7:0] code, input logic last);
    logic [VW-1:0] a, b, r;
    bit            dz;
    expr_result_t  res;
    if (code >= CH_ZERO && code <= CH_NINE) begin
      if (digits_seen != TALLY_MAX) digits_seen++;
      if (calc_depth >= DEPTH) begin
        // stack full: digit dropped, first error sticks
        if (first_error == ST_OK) first_error = ST_OVER;
      end else begin
        calc_stack[calc_depth] = VW'(code - CH_ZERO);
        calc_depth++;
      end
    end else begin
      if (ops_seen != TALLY_MAX) ops_seen++;
      if (calc_depth < 2) begin
        if (first_error == ST_OK) first_error = ST_UNDER;
      end else begin
        b = calc_stack[calc_depth-1];
        a = calc_stack[calc_depth-2];
        r = combine(code, a, b, dz);
        if (dz && first_error == ST_OK) first_error = ST_DIVZERO;
        calc_depth--;
        calc_stack[calc_depth-1] = r;
      end
    end
    if (last) begin
      // priority: recorded error, then no operator, then operand count
      if (first_error != ST_OK)              res.status = first_error;
      else if (ops_seen == '0)               res.status = ST_NOOP;
      else if (digits_seen - ops_seen != 1)  res.status = ST_COUNT;
      else                                   res.status = ST_OK;
      res.value = (calc_depth > 0) ? calc_stack[calc_depth-1][VALUE_OUT_W-1:0] : '0;
      expected_results.push_back(res);
      calc_depth  = 0;
      digits_seen = '0;
      ops_seen    = '0;
      first_error = ST_OK;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && char_valid && char_ready) apply_char(char_code, last_char);
  end

  // ---------------------------------------------------------------------------
  // Result monitor: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    expr_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with none expected: value %0d status %0d", $signed(value), status);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (value !== want.value) begin
          $error("value mismatch: expected %0d, got %0d", $signed(want.value), $signed(value));
          mismatches++;
        end
        if (status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Character driver: bursts of items with random gaps between them
  // ---------------------------------------------------------------------------
  char_item_t pending [$];
  int         burst_left = 1;
  int         gap_left   = 0;

  always @(posedge clk) begin : char_driver
    char_item_t nxt;
    // a slot opens when nothing is offered or the current item goes through now
    if (!rst && (!char_valid || char_ready)) begin
      if (gap_left > 0 || pending.size() == 0) begin
        char_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        nxt = pending.pop_front();
        char_code  <= nxt.code;
        last_char  <= nxt.last;
        char_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 32);
          case ($urandom_range(0, 5))
            0, 1:    gap_left = 0;                       // back-to-back bursts
            2, 3:    gap_left = $urandom_range(1, 3);
            4:       gap_left = $urandom_range(4, 12);
            default: gap_left = $urandom_range(20, 45);  // lands anywhere in a long op
          endcase
        end
      end
    end
  end

  // Result sink: ready follows its own pattern of runs and stalls
  int ready_hold = 0;

  always @(posedge clk) begin : result_sink
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      case ($urandom_range(0, 4))
        0, 1: begin
          result_ready <= 1'b1;
          ready_hold = $urandom_range(1, 60);
        end
        2: begin
          result_ready <= 1'b0;
          ready_hold = $urandom_range(1, 3);
        end
        3: begin
          result_ready <= 1'($urandom_range(0, 1));
          ready_hold = 0;
        end
        default: begin
          result_ready <= 1'b0;
          ready_hold = $urandom_range(15, 40);
        end
      endcase
    end
  end

  // Watchdog: too long with neither channel moving ends the run
  int quiet_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst || (char_valid && char_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_char(input logic [7:0] code, input logic last);
    char_item_t it;
    it.code = code;
    it.last = last;
    pending.push_back(it);
  endtask

  // Text as one expression; the final character closes it unless told otherwise
  task automatic queue_text(input string s, input bit close = 1'b1);
    for (int i = 0; i < s.len(); i++) queue_char(s[i], close && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_non_digit();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c >= CH_ZERO && c <= CH_NINE);
    return c;
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 11))
      0, 1, 2:  return CH_PLUS;
      3, 4, 5:  return CH_MINUS;
      6, 7, 8:  return CH_MUL;
      9, 10:    return CH_DIV;
      default:  return rand_non_digit();  // unknown character, still an operator slot
    endcase
  endfunction

  // Well-formed expression with n_digits operands; stack height never above max_depth,
  // so max_depth past the stack size produces overflow on purpose.
  task automatic queue_expression(input int n_digits, input int max_depth);
    logic [7:0] seq [$];
    int         depth = 0;
    int         left  = n_digits;
    while (left > 0 || depth > 1) begin
      if (left > 0 && (depth < 2 || (depth < max_depth && $urandom_range(0, 1)))) begin
        seq.push_back(rand_digit());
        depth++;
        left--;
      end else begin
        seq.push_back(rand_operator());
        depth--;
      end
    end
    foreach (seq[i]) queue_char(seq[i], i == seq.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------
  initial begin : run_control
    int base;
    int n;

    // directed: field extremes, every operation, error cases
    queue_char(8'h00, 1'b1);     // unknown char on empty stack: underflow
    queue_text("34+");
    queue_text("29-");           // negative result
    queue_text("78*");
    queue_text("07-2/");         // -7 / 2 truncates to -3
    queue_text("50/");           // divide by zero
    queue_text("5");             // no operator
    queue_text("123+");          // operand count mismatch
    queue_text("45", 1'b0);
    queue_char(8'hFF, 1'b1);     // unknown char with two operands pushes 0

    // stack full: 17th digit dropped, overflow reported
    repeat (DEPTH + 1) queue_char(CH_NINE, 1'b0);
    queue_char(CH_PLUS, 1'b1);

    // build 2^31 (wraps to most negative), then divide by -1
    queue_char(CH_ZERO + 8'd2, 1'b0);
    repeat (30) begin
      queue_char(CH_ZERO + 8'd2, 1'b0);
      queue_char(CH_MUL, 1'b0);
    end
    queue_text("01-/");

    // random: mostly well-formed expressions, some deep ones, noise and broken streams
    base = pending.size();
    while (pending.size() - base < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: queue_expression($urandom_range(1, 6), DEPTH);
        6:                queue_expression($urandom_range(6, 14), DEPTH);
        7:                queue_expression($urandom_range(14, 20), $urandom_range(15, 18));
        8: begin
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++)
            queue_char(8'($urandom_range(0, 255)), (i == n - 1) || ($urandom_range(0, 7) == 0));
        end
        default: begin
          n = $urandom_range(1, 10);
          for (int i = 0; i < n; i++)
            queue_char($urandom_range(0, 1) ? rand_digit() : rand_operator(), i == n - 1);
        end
      endcase
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // sampled on the falling edge, away from the clocked blocks
    do @(negedge clk); while (pending.size() != 0 || char_valid);
    do @(negedge clk); while (expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
